// ----- hdl/tmsp_pkg.sv -----
package tmsp_pkg;

  localparam int unsigned PhW  = 4;
  localparam int unsigned StW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PhW-1:0] PH_MAGIC   = 4'd0;
  localparam logic [PhW-1:0] PH_VERSION = 4'd1;
  localparam logic [PhW-1:0] PH_FLAGS   = 4'd2;
  localparam logic [PhW-1:0] PH_MSGTYPE = 4'd3;
  localparam logic [PhW-1:0] PH_PAYLEN  = 4'd4;
  localparam logic [PhW-1:0] PH_NAMELEN = 4'd5;
  localparam logic [PhW-1:0] PH_NAME    = 4'd6;
  localparam logic [PhW-1:0] PH_TYPE    = 4'd7;
  localparam logic [PhW-1:0] PH_DATALEN = 4'd8;
  localparam logic [PhW-1:0] PH_DATA    = 4'd9;
  localparam logic [PhW-1:0] PH_TRAIL   = 4'd10;
  localparam logic [PhW-1:0] PH_DISCARD = 4'd11;

  localparam logic [StW-1:0] ST_BUSY    = 3'd0;
  localparam logic [StW-1:0] ST_OK      = 3'd1;
  localparam logic [StW-1:0] ST_MAGIC   = 3'd2;
  localparam logic [StW-1:0] ST_VERSION = 3'd3;
  localparam logic [StW-1:0] ST_TRUNC   = 3'd4;
  localparam logic [StW-1:0] ST_TYPE    = 3'd5;
  localparam logic [StW-1:0] ST_LENGTH  = 3'd6;

  localparam logic [CfgIdxW-1:0] REG_MAGIC   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VERSION = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TEXT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WORD32  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WORD64  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BLOB    = 3'd5;

  localparam logic [31:0] MAGIC_RST   = 32'h4C50_5446;
  localparam logic [7:0]  VERSION_RST = 8'd1;
  localparam logic [7:0]  TEXT_RST    = 8'd10;
  localparam logic [7:0]  WORD32_RST  = 8'd2;
  localparam logic [7:0]  WORD64_RST  = 8'd3;
  localparam logic [7:0]  BLOB_RST    = 8'd11;

  localparam logic [15:0] WORD32_LEN = 16'd4;
  localparam logic [15:0] WORD64_LEN = 16'd8;
  localparam logic [15:0] MAGIC_LEN  = 16'd4;
  localparam logic [15:0] MSGTYPE_LEN = 16'd2;
  localparam logic [15:0] PAYLEN_LEN = 16'd4;
  localparam logic [15:0] DATALEN_LEN = 16'd2;

  localparam logic [2:0] KIND_TEXT    = 3'd0;
  localparam logic [2:0] KIND_WORD32  = 3'd1;
  localparam logic [2:0] KIND_WORD64  = 3'd2;
  localparam logic [2:0] KIND_BLOB    = 3'd3;
  localparam logic [2:0] KIND_UNKNOWN = 3'd4;

  typedef struct packed {
    logic [PhW-1:0] part;
    logic [7:0]     byte_echo;
    logic [63:0]    value;
    logic           value_valid;
    logic [1:0]     field_kind;
    logic [StW-1:0] status;
    logic           packet_done;
  } res_t;

  function automatic logic [2:0] kind_of(input logic [7:0] code, input logic [7:0] c_text,
                                         input logic [7:0] c_w32, input logic [7:0] c_w64,
                                         input logic [7:0] c_blob);
    logic [2:0] k;
    if (code == c_text) begin
      k = KIND_TEXT;
    end else if (code == c_w32) begin
      k = KIND_WORD32;
    end else if (code == c_w64) begin
      k = KIND_WORD64;
    end else if (code == c_blob) begin
      k = KIND_BLOB;
    end else begin
      k = KIND_UNKNOWN;
    end
    return k;
  endfunction

endpackage

// ----- hdl/tmsp_in_if.sv -----
interface tmsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ----- hdl/tmsp_out_if.sv -----
interface tmsp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  part;
  logic [7:0]  byte_echo;
  logic [63:0] value;
  logic        value_valid;
  logic [1:0]  field_kind;
  logic [2:0]  status;
  logic        packet_done;

  modport source (output valid, output part, output byte_echo, output value,
                  output value_valid, output field_kind, output status,
                  output packet_done, input ready);
  modport sink (input valid, input part, input byte_echo, input value,
                input value_valid, input field_kind, input status,
                input packet_done, output ready);
endinterface

// ----- hdl/tlv_message_stream_parser.sv -----
// Byte-serial parser for TLV packets: a 12-byte big-endian header followed by fields.
// Input channel in_i carries one packet byte per item with an end-of-buffer mark.
// Output channel out_o carries one result item per input byte: the part the byte
// belongs to, the byte itself, any completed numeric value, the field kind and status.
// The configuration port writes the expected magic, the version and the four type
// codes; the user must write it only while no item is in flight, as the block
// itself does not enforce this. An accepted byte's result is registered in the result
// register, or in the skid register when that is full. Throughput is one byte
// per cycle while ready is high; the phase machine and its counters update per byte.
// The output side has a result register and one skid register, so a byte is still
// accepted while a finished result waits; ready drops only when both are full and
// returns once the receiver takes a result.
// Reset restores the register defaults, puts the parser at the start of a packet
// and empties the output. The byte after an end-of-buffer mark starts a new packet.
module tlv_message_stream_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tmsp_in_if.sink                           in_i,
  tmsp_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [tmsp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tmsp_pkg::CfgDataW-1:0]     cfg_data_i
);
  import tmsp_pkg::*;

  logic [31:0] magic_q;
  logic [7:0]  version_q, text_q, w32_q, w64_q, blob_q;

  logic [PhW-1:0] phase_q, phase_d;
  logic [15:0]    cnt_q, cnt_d;
  logic [32:0]    off_q, off_d;
  logic [31:0]    paylen_q, paylen_d;
  logic [7:0]     namelen_q, namelen_d;
  logic [7:0]     kcode_q, kcode_d;
  logic [15:0]    dlen_q, dlen_d;
  logic [63:0]    acc_q, acc_d;
  logic [StW-1:0] fstat_q, fstat_d;

  res_t res_d, out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept, pop;

  logic [7:0] b;
  logic       eob;
  logic [2:0] k_byte, k_stored;

  assign b        = in_i.data_byte;
  assign eob      = in_i.end_of_buffer;
  assign in_i.ready = !skid_valid_q;
  assign accept   = in_i.valid && in_i.ready;
  assign pop      = out_valid_q && out_o.ready;

  assign k_byte   = kind_of(b, text_q, w32_q, w64_q, blob_q);
  assign k_stored = kind_of(kcode_q, text_q, w32_q, w64_q, blob_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= MAGIC_RST;
      version_q <= VERSION_RST;
      text_q    <= TEXT_RST;
      w32_q     <= WORD32_RST;
      w64_q     <= WORD64_RST;
      blob_q    <= BLOB_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC:   magic_q   <= cfg_data_i;
        REG_VERSION: version_q <= cfg_data_i[7:0];
        REG_TEXT:    text_q    <= cfg_data_i[7:0];
        REG_WORD32:  w32_q     <= cfg_data_i[7:0];
        REG_WORD64:  w64_q     <= cfg_data_i[7:0];
        REG_BLOB:    blob_q    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic fin;
    logic [StW-1:0] fin_st;
    logic ent;
    logic [PhW-1:0] ent_ph;
    logic [2:0] k;
    fin    = 1'b0;
    fin_st = ST_BUSY;
    ent    = 1'b0;
    ent_ph = phase_q;
    k      = KIND_UNKNOWN;

    phase_d   = phase_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    paylen_d  = paylen_q;
    namelen_d = namelen_q;
    kcode_d   = kcode_q;
    dlen_d    = dlen_q;
    acc_d     = acc_q;
    fstat_d   = fstat_q;

    res_d.part        = phase_q;
    res_d.byte_echo   = b;
    res_d.value       = 64'd0;
    res_d.value_valid = 1'b0;
    res_d.field_kind  = 2'd0;
    res_d.status      = fstat_q;
    res_d.packet_done = 1'b0;

    if (phase_q != PH_TRAIL && phase_q != PH_DISCARD) begin
      acc_d = {acc_q[55:0], b};
      cnt_d = cnt_q + 16'd1;
      if (phase_q >= PH_NAMELEN) begin
        off_d = off_q + 33'd1;
      end

      case (phase_q)
        PH_MAGIC: begin
          if (cnt_d == MAGIC_LEN) begin
            res_d.value       = {32'd0, acc_d[31:0]};
            res_d.value_valid = 1'b1;
            if (acc_d[31:0] != magic_q) begin
              fin = 1'b1;
              fin_st = ST_MAGIC;
            end else begin
              ent = 1'b1;
              ent_ph = PH_VERSION;
            end
          end
        end
        PH_VERSION: begin
          res_d.value       = {56'd0, b};
          res_d.value_valid = 1'b1;
          if (b != version_q) begin
            fin = 1'b1;
            fin_st = ST_VERSION;
          end else begin
            ent = 1'b1;
            ent_ph = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          res_d.value       = {56'd0, b};
          res_d.value_valid = 1'b1;
          ent = 1'b1;
          ent_ph = PH_MSGTYPE;
        end
        PH_MSGTYPE: begin
          if (cnt_d == MSGTYPE_LEN) begin
            res_d.value       = {48'd0, acc_d[15:0]};
            res_d.value_valid = 1'b1;
            ent = 1'b1;
            ent_ph = PH_PAYLEN;
          end
        end
        PH_PAYLEN: begin
          if (cnt_d == PAYLEN_LEN) begin
            res_d.value       = {32'd0, acc_d[31:0]};
            res_d.value_valid = 1'b1;
            paylen_d = acc_d[31:0];
            off_d    = 33'd0;
            if (acc_d[31:0] == 32'd0) begin
              fin = 1'b1;
              fin_st = ST_OK;
            end else begin
              ent = 1'b1;
              ent_ph = PH_NAMELEN;
            end
          end
        end
        PH_NAMELEN: begin
          res_d.value       = {56'd0, b};
          res_d.value_valid = 1'b1;
          namelen_d = b;
          ent = 1'b1;
          ent_ph = (b != 8'd0) ? PH_NAME : PH_TYPE;
        end
        PH_NAME: begin
          if (cnt_d >= {8'd0, namelen_q}) begin
            ent = 1'b1;
            ent_ph = PH_TYPE;
          end
        end
        PH_TYPE: begin
          res_d.value       = {56'd0, b};
          res_d.value_valid = 1'b1;
          kcode_d = b;
          res_d.field_kind = (k_byte != KIND_UNKNOWN) ? k_byte[1:0] : 2'd0;
          ent = 1'b1;
          ent_ph = PH_DATALEN;
        end
        PH_DATALEN: begin
          k = k_stored;
          res_d.field_kind = (k != KIND_UNKNOWN) ? k[1:0] : 2'd0;
          if (cnt_d == DATALEN_LEN) begin
            res_d.value       = {48'd0, acc_d[15:0]};
            res_d.value_valid = 1'b1;
            dlen_d = acc_d[15:0];
            if (k == KIND_UNKNOWN) begin
              fin = 1'b1;
              fin_st = ST_TYPE;
            end else if ((k == KIND_WORD32 && acc_d[15:0] != WORD32_LEN) ||
                         (k == KIND_WORD64 && acc_d[15:0] != WORD64_LEN)) begin
              fin = 1'b1;
              fin_st = ST_LENGTH;
            end else if (acc_d[15:0] == 16'd0) begin
              if (off_d >= {1'b0, paylen_q}) begin
                fin = 1'b1;
                fin_st = ST_OK;
              end else begin
                ent = 1'b1;
                ent_ph = PH_NAMELEN;
              end
            end else begin
              ent = 1'b1;
              ent_ph = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          k = k_stored;
          res_d.field_kind = (k != KIND_UNKNOWN) ? k[1:0] : 2'd0;
          if (cnt_d >= dlen_q) begin
            if (k == KIND_WORD32 || k == KIND_WORD64) begin
              res_d.value       = acc_d;
              res_d.value_valid = 1'b1;
            end
            if (off_d >= {1'b0, paylen_q}) begin
              fin = 1'b1;
              fin_st = ST_OK;
            end else begin
              ent = 1'b1;
              ent_ph = PH_NAMELEN;
            end
          end
        end
        default: begin
        end
      endcase

      if (!fin && eob) begin
        fin = 1'b1;
        fin_st = ST_TRUNC;
      end
      if (fin) begin
        fstat_d = fin_st;
        ent = 1'b1;
        ent_ph = (fin_st == ST_OK) ? PH_TRAIL : PH_DISCARD;
      end
      if (ent) begin
        phase_d = ent_ph;
        cnt_d   = 16'd0;
        acc_d   = 64'd0;
      end
      res_d.status      = fstat_d;
      res_d.packet_done = fin;
    end

    if (eob) begin
      phase_d   = PH_MAGIC;
      cnt_d     = 16'd0;
      acc_d     = 64'd0;
      off_d     = 33'd0;
      paylen_d  = 32'd0;
      namelen_d = 8'd0;
      kcode_d   = 8'd0;
      dlen_d    = 16'd0;
      fstat_d   = ST_BUSY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_MAGIC;
      cnt_q     <= 16'd0;
      off_q     <= 33'd0;
      paylen_q  <= 32'd0;
      namelen_q <= 8'd0;
      kcode_q   <= 8'd0;
      dlen_q    <= 16'd0;
      acc_q     <= 64'd0;
      fstat_q   <= ST_BUSY;
    end else if (accept) begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      off_q     <= off_d;
      paylen_q  <= paylen_d;
      namelen_q <= namelen_d;
      kcode_q   <= kcode_d;
      dlen_q    <= dlen_d;
      acc_q     <= acc_d;
      fstat_q   <= fstat_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.part        = out_q.part;
  assign out_o.byte_echo   = out_q.byte_echo;
  assign out_o.value       = out_q.value;
  assign out_o.value_valid = out_q.value_valid;
  assign out_o.field_kind  = out_q.field_kind;
  assign out_o.status      = out_q.status;
  assign out_o.packet_done = out_q.packet_done;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the result register is empty");

  a_trail_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRAIL) |-> (fstat_q == ST_OK))
    else $error("trailing phase without ok status");

  a_busy_in_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_TRAIL && phase_q != PH_DISCARD) |-> (fstat_q == ST_BUSY))
    else $error("final status set while still parsing");

  a_done_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.packet_done) |-> (out_q.status != ST_BUSY && !out_q.value_valid ||
                                            out_q.status != ST_BUSY))
    else $error("packet done reported with busy status");

  a_no_value_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.part == PH_TRAIL || out_q.part == PH_DISCARD))
      |-> (!out_q.value_valid && !out_q.packet_done))
    else $error("value or done reported on a byte after the final status");

endmodule
